[hw/rtl/assert_macros.svh]
// Assertion macros shared by the checker files.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, masked during reset.
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define ASSERT_NXT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/mmcs_pkg.sv]
package mmcs_pkg;

  localparam int PIX_W = 8;
  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
  localparam logic [PIX_W-1:0] PIX_MIN = 8'd0;

  // one quotient bit per divider step
  localparam int DIV_STEPS = PIX_W;
  localparam int CNT_W = $clog2(DIV_STEPS);

  // request kinds
  localparam logic REQ_MEASURE = 1'b0;
  localparam logic REQ_APPLY = 1'b1;

  // result source select
  localparam logic [1:0] RES_QUOT = 2'd0;
  localparam logic [1:0] RES_ZERO = 2'd1;
  localparam logic [1:0] RES_FULL = 2'd2;

  typedef logic [PIX_W-1:0] pix_t;

  // controller to datapath
  typedef struct packed {
    logic measure;  // fold input pixel into min/max
    logic start;    // latch pixel, set up divider
    logic step;     // one restoring division step
    logic load;     // move result into output register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;  // output register can take a new result this cycle
  } ctrl_sts_t;

endpackage

[hw/rtl/min_max_contrast_stretch_top.sv]
// Measure transfer: no result; back-to-back at one per cycle while no apply is in flight.
// Apply transfer: result follows the input transfer after a setup step,
// 8 restoring divider steps and an output load; input stays closed until that load.
// The shared 8-step divider sets the apply rate; a waiting output stalls the load.
// Synchronous active-high rst: min = 255, max = 0, output empty.
module min_max_contrast_stretch_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] pixel
  input  logic [1:0] s_axis_tuser,   // [0] req_type, [1] frame_start
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [7:0] stretched_pixel
);
  import mmcs_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  mmcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_req   (s_axis_tuser[0]),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mmcs_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .in_pixel       (s_axis_tdata),
    .in_frame_start (s_axis_tuser[1]),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_pixel      (m_axis_tdata)
  );

endmodule

[hw/rtl/mmcs_ctrl.sv]
module mmcs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_req,
  output logic               in_ready,
  input  mmcs_pkg::ctrl_sts_t sts,
  output mmcs_pkg::ctrl_cmd_t cmd
);
  import mmcs_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    cmd         = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_req == REQ_APPLY) begin
            cmd.start  = 1'b1;
            cnt_next   = '0;
            state_next = ST_DIV;
          end else begin
            cmd.measure = 1'b1;
          end
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (sts.out_free) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

[hw/rtl/mmcs_dpath.sv]
module mmcs_dpath (
  input  logic                clk,
  input  logic                rst,
  input  mmcs_pkg::ctrl_cmd_t cmd,
  output mmcs_pkg::ctrl_sts_t sts,
  input  mmcs_pkg::pix_t      in_pixel,
  input  logic                in_frame_start,
  output logic                out_valid,
  input  logic                out_ready,
  output mmcs_pkg::pix_t      out_pixel
);
  import mmcs_pkg::*;

  pix_t        running_min;
  pix_t        running_max;
  pix_t        base_min;
  pix_t        base_max;
  pix_t        diff;
  logic [15:0] num;
  pix_t        rem;
  pix_t        shreg;     // numerator low bits in, quotient bits out
  pix_t        den;
  logic [1:0]  res_sel;
  logic [8:0]  trial;
  logic        q_bit;
  pix_t        result;

  // min/max tracking, frame start restarts from reset values
  always_comb begin
    base_min = in_frame_start ? PIX_MAX : running_min;
    base_max = in_frame_start ? PIX_MIN : running_max;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_min <= PIX_MAX;
      running_max <= PIX_MIN;
    end else if (cmd.measure) begin
      running_min <= (in_pixel < base_min) ? in_pixel : base_min;
      running_max <= (in_pixel > base_max) ? in_pixel : base_max;
    end
  end

  // numerator 255*(p-min) as (d<<8)-d
  assign diff = in_pixel - running_min;
  assign num  = {diff, 8'd0} - {8'd0, diff};

  // restoring division step; remainder stays below divisor
  assign trial = {rem, shreg[PIX_W-1]};
  assign q_bit = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem   <= num[15:8];
      shreg <= num[7:0];
      den   <= running_max - running_min;
      if ((running_max <= running_min) || (in_pixel <= running_min)) begin
        res_sel <= RES_ZERO;
      end else if (in_pixel >= running_max) begin
        res_sel <= RES_FULL;
      end else begin
        res_sel <= RES_QUOT;
      end
    end else if (cmd.step) begin
      rem   <= q_bit ? PIX_W'(trial - {1'b0, den}) : trial[PIX_W-1:0];
      shreg <= {shreg[PIX_W-2:0], q_bit};
    end
  end

  // result select
  always_comb begin
    case (res_sel)
      RES_ZERO: result = PIX_MIN;
      RES_FULL: result = PIX_MAX;
      default:  result = shreg;
    endcase
  end

  // output register
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_pixel <= result;
    end
  end

endmodule

[hw/rtl/mmcs_checker.sv]
`include "assert_macros.svh"

module mmcs_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [1:0] s_axis_tuser,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // stalled result holds its value
  `ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // an apply transfer occupies the divider, so input closes next cycle
  `ASSERT_NXT(a_apply_busy, s_axis_tvalid && s_axis_tready && s_axis_tuser[0], !s_axis_tready)

  // a measure transfer never produces a result
  `ASSERT_NXT(a_measure_quiet, !m_axis_tvalid && s_axis_tvalid && s_axis_tready && !s_axis_tuser[0], !m_axis_tvalid)

  // input closed means no input transfer can be taken
  `ASSERT_IMP(a_idle_ready_ok, !s_axis_tready, !(s_axis_tvalid && s_axis_tready))

  // reset empties the output
  `ASSERT_NXT_RST(a_rst_empty, rst, !m_axis_tvalid)

endmodule

bind min_max_contrast_stretch_top mmcs_checker u_mmcs_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
